@@ sv/radsp_pkg.sv @@
// radial sine plasma table: shared constants and types
// no dependencies; imported by radial_sine_plasma_table_unit and its testbench
`timescale 1ns / 1ps
`default_nettype none

package radsp_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF      = 11;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // configuration reset values
    localparam logic [11:0] WIDTH_RST  = 12'd800;
    localparam logic [11:0] HEIGHT_RST = 12'd600;

    // datapath widths, set by the 12-bit geometry registers
    localparam int DX_W     = 13;  // signed offset from centre
    localparam int SQ_W     = 26;  // 16 + dx^2 + dy^2
    localparam int ROOT_W   = 21;  // sqrt of (sum << 16)
    localparam int SQ_REM_W = ROOT_W + 3;
    localparam int PROD_W   = 51;  // radius times 1/(2pi) in q32
    localparam int NUM_W    = 59;  // divider numerator
    localparam int DEN_W    = 24;  // divider denominator
    localparam int DEN_MIN_BITS = 11;  // every divisor is at least 2^11

    // fixed-point constants
    localparam logic [29:0] INV2PI_Q32  = 30'd683565276;
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [ROOT_W-1:0] RADIUS_OFS = ROOT_W'(1024);
    localparam logic [DEN_W-1:0]  DIV_MODE1  = DEN_W'(4864);
    localparam logic [3:0]        DIV_MODE0_MUL = 4'd7;  // 3584 = 7 << 9

    localparam logic [7:0] VALUE_MAX = 8'd180;

endpackage

`default_nettype wire

@@ sv/radial_sine_plasma_table_unit.sv @@
// radial sine plasma table unit: pixel coordinate to plasma byte
// fully pipelined; depends on radsp_pkg
// throughput: one request per cycle; the 21-step square root and the one-bit-per-stage
//   divider are laid out as pipeline stages, so the whole pipe stalls only on out_ready
// reset: rst_n clears the valid bits and restores width 800, height 600, mode 0
`timescale 1ns / 1ps
`default_nettype none

module radial_sine_plasma_table_unit
    import radsp_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [COORD_BITS-1:0] x_pos,
    input  wire logic [COORD_BITS-1:0] y_pos,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 plasma_value,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TB        = SINE_TABLE_BITS;
    localparam int ROM_DEPTH = 1 << TB;
    localparam int QB        = TB + 2;          // quotient bits kept (turn fraction top)
    localparam int SH        = 32 - QB;         // dropped fraction bits
    localparam int NQ        = NUM_W - DEN_MIN_BITS - SH;  // divider stages
    localparam int SQ_STAGES = ROOT_W;
    localparam int NSTAGE    = 2 + SQ_STAGES + 2 + NQ + 2;

    // quarter-wave rom contents
    typedef logic [15:0] rom_t [ROM_DEPTH];

    // shift-and-subtract quotient for the rom build
    function automatic longint unsigned cdiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_rom();
        rom_t              r;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint unsigned   e;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            x    = (longint'(PI_HALF_Q30) * longint'(2 * i + 1)) >> (TB + 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x2) >> 30;
                term = cdiv64(term, longint'((2 * k) * (2 * k + 1)));
                if ((k & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            e = (longint'(sum) + 64'd8192) >> 14;
            if (e > 64'd65535)
                e = 64'd65535;
            r[i] = e[15:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration registers
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic        mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            mode_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // pipeline advance and valid chain
    logic [NSTAGE-1:0] vld_reg;
    logic              adv;

    assign adv       = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
    end

    // stage 1: offsets from the centre, squared
    logic signed [DX_W-1:0] dx_next;
    logic signed [DX_W-1:0] dy_next;
    logic signed [SQ_W-1:0] dxx_next;
    logic signed [SQ_W-1:0] dyy_next;
    logic [SQ_W-1:0]        dxx_reg;
    logic [SQ_W-1:0]        dyy_reg;

    assign dx_next  = $signed(DX_W'(x_pos)) - $signed({2'b00, width_reg[11:1]});
    assign dy_next  = $signed(DX_W'(y_pos)) - $signed({2'b00, height_reg[11:1]});
    assign dxx_next = dx_next * dx_next;
    assign dyy_next = dy_next * dy_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxx_reg <= dxx_next;
            dyy_reg <= dyy_next;
        end
    end

    // stage 2: sum under the root
    logic [SQ_W-1:0] s_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            s_reg <= SQ_W'(16) + dxx_reg + dyy_reg;
    end

    // square root of (s << 16), one root bit per stage
    logic [SQ_REM_W-1:0] sq_rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0]   sq_root_reg [SQ_STAGES];
    logic [SQ_W-1:0]     sq_s_reg    [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_sqrt
        localparam int J = SQ_STAGES - 1 - g;
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [ROOT_W-1:0]   root_in;
        logic [ROOT_W-1:0]   root_next;
        logic [SQ_W-1:0]     s_in;
        logic [1:0]          pair;
        logic                ge;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = s_reg;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[g-1];
            assign root_in = sq_root_reg[g-1];
            assign s_in    = sq_s_reg[g-1];
        end

        // the low 16 bits of the radicand are zero
        if (J >= 8)
        begin : g_pair
            assign pair = s_in[2*J-15 : 2*J-16];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh    = {rem_in[SQ_REM_W-3:0], pair};
        assign trial     = {1'b0, root_in, 2'b01};
        assign ge        = rem_sh >= trial;
        assign rem_next  = ge ? rem_sh - trial : rem_sh;
        assign root_next = {root_in[ROOT_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[g]  <= rem_next;
                sq_root_reg[g] <= root_next;
                sq_s_reg[g]    <= s_in;
            end
        end
    end

    // radius times 1/(2pi)
    logic [ROOT_W-1:0] radius_next;
    logic [PROD_W-1:0] prod_reg;

    assign radius_next = sq_root_reg[SQ_STAGES-1] - RADIUS_OFS;

    always_ff @(posedge clk)
    begin
        if (adv)
            prod_reg <= PROD_W'(radius_next) * PROD_W'(INV2PI_Q32);
    end

    // numerator: mode 0 carries the factor 320
    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] num_reg;

    assign num_next = mode_reg ? NUM_W'(prod_reg)
                               : (NUM_W'(prod_reg) << 8) + (NUM_W'(prod_reg) << 6);

    always_ff @(posedge clk)
    begin
        if (adv)
            num_reg <= num_next;
    end

    // divisor from the static configuration
    logic [11:0]      width_eff;
    logic [DEN_W-1:0] den;

    assign width_eff = (width_reg == 12'd0) ? 12'd1 : width_reg;
    assign den       = mode_reg ? DIV_MODE1
                                : (DEN_W'(width_eff) * DEN_W'(DIV_MODE0_MUL)) << 9;

    // restoring divider, one quotient bit per stage, keeps the turn fraction bits
    logic [NUM_W-1:0] dv_rem_reg [NQ];
    logic [QB-1:0]    dv_q_reg   [NQ];

    for (genvar g = 0; g < NQ; g++)
    begin : g_div
        localparam int I = NQ - 1 - g;
        localparam int K = I + SH;
        logic [NUM_W-1:0] rem_in;
        logic [NUM_W-1:0] rem_next;
        logic [QB-1:0]    q_in;
        logic [QB-1:0]    q_next;
        logic             ge;

        if (g == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = dv_rem_reg[g-1];
            assign q_in   = dv_q_reg[g-1];
        end

        assign ge       = (rem_in >> K) >= NUM_W'(den);
        assign rem_next = ge ? rem_in - (NUM_W'(den) << K) : rem_in;

        if (I < QB)
        begin : g_keep
            always_comb
            begin
                q_next    = q_in;
                q_next[I] = ge;
            end
        end
        else
        begin : g_drop
            assign q_next = q_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[g] <= rem_next;
                dv_q_reg[g]   <= q_next;
            end
        end
    end

    // quadrant fold and rom read
    logic [QB-1:0] addr;
    logic [1:0]    quad;
    logic [TB-1:0] pos;
    logic [15:0]   rom_q_reg;
    logic          neg_reg;

    assign addr = dv_q_reg[NQ-1];
    assign quad = addr[QB-1:QB-2];
    assign pos  = quad[0] ? ~addr[TB-1:0] : addr[TB-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rom_q_reg <= SINE_ROM[pos];
            neg_reg   <= quad[1];
        end
    end

    // scale (sin + 1) * 90 and clamp
    logic [16:0] biased;
    logic [23:0] scaled;
    logic [7:0]  value_next;
    logic [7:0]  value_reg;

    assign biased     = neg_reg ? 17'd65536 - 17'(rom_q_reg) : 17'd65536 + 17'(rom_q_reg);
    assign scaled     = 24'(biased) * 24'd90;
    assign value_next = (scaled[23:16] > VALUE_MAX) ? VALUE_MAX : scaled[23:16];

    always_ff @(posedge clk)
    begin
        if (adv)
            value_reg <= value_next;
    end

    assign plasma_value = value_reg;

    // checks
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> plasma_value <= VALUE_MAX)
        else $error("plasma value out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(value_reg))
        else $error("pipeline moved during a stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[0] == $past(in_valid))
        else $error("accepted request not tracked");

endmodule

`default_nettype wire

@@ verif/radial_sine_plasma_table_unit_test.sv @@
// testbench for radial_sine_plasma_table_unit: coordinate requests checked against a
// built-in plasma predictor; depends on radsp_pkg and the unit
`timescale 1ns / 1ps

module radial_sine_plasma_table_unit_test;
    import radsp_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int TB = SINE_TABLE_BITS_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CB-1:0] x_pos = '0;
    logic [CB-1:0] y_pos = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] plasma_value;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [11:0] cur_width = WIDTH_RST;
    logic [11:0] cur_height = HEIGHT_RST;
    logic cur_mode = 1'b0;
    longint unsigned quarter_rom [0:(1<<TB)-1];
    longint cycles = 0;
    int out_wait = 0;
    int out_draw;

    radial_sine_plasma_table_unit DUT (.*);

    always #10 clk = ~clk;

    // plasma scoreboard
    class plasma_board;
        logic [7:0] pending [$];
        int errors = 0;
        function void note(logic [7:0] v);
            pending = {pending, v};
        endfunction
        function void check(logic [7:0] got);
            logic [7:0] want;
            if (pending.size() == 0) begin
                $error("plasma_value unexpected result %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                $error("plasma_value expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    plasma_board board = new();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned rom_entry(longint unsigned i);
        longint unsigned x, x2, term, e;
        longint sum;
        x = (64'd1686629713 * (2 * i + 1)) >> (TB + 1);
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k & 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        e = (longint'(sum) + (1 << 13)) >> 14;
        return (e > 65535) ? 65535 : e;
    endfunction

    // expected plasma byte for one coordinate
    function automatic logic [7:0] plasma_of(logic [CB-1:0] px, logic [CB-1:0] py);
        longint dx, dy, sn, v;
        longint unsigned s, r, turns, w, addr, quad, pos, mval;
        dx = longint'(px) - longint'(cur_width >> 1);
        dy = longint'(py) - longint'(cur_height >> 1);
        s = 16 + dx * dx + dy * dy;
        r = int_sqrt(s << 16) - 1024;
        if (cur_mode) turns = (r * 64'd683565276) / 4864;
        else begin
            w = (cur_width != 0) ? cur_width : 1;
            turns = (r * 64'd683565276 * 320) / (3584 * w);
        end
        turns &= 64'hFFFF_FFFF;
        addr = turns >> (32 - (TB + 2));
        quad = (addr >> TB) & 3;
        mval = (64'd1 << TB) - 1;
        pos = addr & mval;
        if (quad & 1) pos = mval - pos;
        sn = quarter_rom[pos];
        if (quad & 2) sn = -sn;
        v = ((sn + 65536) * 90) / 65536;
        if (v < 0) v = 0;
        if (v > 180) v = 180;
        return v[7:0];
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  cur_width = val;
            CFG_HEIGHT: cur_height = val;
            CFG_MODE:   cur_mode = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_coord(logic [CB-1:0] px, logic [CB-1:0] py);
        in_valid <= 1'b1;
        x_pos <= px;
        y_pos <= py;
        do @(posedge clk); while (!in_ready);
        board.note(plasma_of(px, py));
    endtask

    task automatic gap_after_send();
        int g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (g != 0) begin
            in_valid <= 1'b0;
            idle_cycles(g);
        end
    endtask

    // drain the pipe before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        idle_cycles(80);
    endtask

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            logic [CB-1:0] px, py;
            if ($urandom_range(0, 3) == 0) begin
                px = CB'($urandom);
                py = CB'($urandom);
            end else begin
                px = CB'($urandom_range(0, (cur_width > 2047) ? 2047 : cur_width));
                py = CB'($urandom_range(0, (cur_height > 2047) ? 2047 : cur_height));
            end
            send_coord(px, py);
            gap_after_send();
        end
    endtask

    // result side: out_ready is held low for a randomly drawn wait after each accepted result
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            board.check(plasma_value);
            out_draw = $urandom_range(0, 8);
            out_wait <= out_draw;
            out_ready <= (out_draw == 0);
        end else if (out_wait > 1)
            out_wait <= out_wait - 1;
        else begin
            out_wait <= 0;
            out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < (1 << TB); i++) quarter_rom[i] = rom_entry(i);
        idle_cycles(12);
        rst_n <= 1'b1;
        idle_cycles(2);

        // directed: reset geometry, corners, centre, out-of-table coordinates
        send_coord(0, 0);
        send_coord(400, 300);
        send_coord(2047, 2047);
        send_coord(0, 2047);
        send_coord(2047, 0);
        send_coord(401, 300);
        send_coord(11'h555, 11'h2AA);
        send_coord(11'h2AA, 11'h555);
        settle();
        write_reg(CFG_MODE, 12'd1);
        send_coord(400, 300);
        send_coord(0, 0);
        send_coord(2047, 2047);
        send_coord(1000, 37);
        settle();
        // zero width and maximum geometry
        write_reg(CFG_WIDTH, 12'd0);
        write_reg(CFG_HEIGHT, 12'hFFF);
        write_reg(CFG_MODE, 12'd0);
        send_coord(0, 0);
        send_coord(2047, 2047);
        send_coord(5, 2047);
        settle();
        write_reg(CFG_WIDTH, 12'hFFF);
        write_reg(CFG_HEIGHT, 12'd1);
        send_coord(2047, 0);
        send_coord(0, 1);
        send_coord(1024, 2047);
        settle();

        // random phases over several geometries
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(CFG_WIDTH, 12'd1); write_reg(CFG_HEIGHT, 12'd1); end
                1: begin write_reg(CFG_WIDTH, 12'd2048); write_reg(CFG_HEIGHT, 12'd2048); end
                2: begin write_reg(CFG_WIDTH, 12'd320); write_reg(CFG_HEIGHT, 12'd200); end
                default: begin
                    write_reg(CFG_WIDTH, 12'($urandom_range(0, 4095)));
                    write_reg(CFG_HEIGHT, 12'($urandom_range(0, 4095)));
                end
            endcase
            write_reg(CFG_MODE, 12'($urandom_range(0, 1)));
            random_batch(125);
            settle();
        end

        while (board.pending.size() != 0) @(posedge clk);
        idle_cycles(100);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/radsp_pkg.sv
sv/radial_sine_plasma_table_unit.sv
verif/radial_sine_plasma_table_unit_test.sv
